/* src/fifo_overwrite_peek_burst_defines.svh */
// Assertion macros shared by the ring buffer modules.
`ifndef FIFO_OVERWRITE_PEEK_BURST_DEFINES_SVH
`define FIFO_OVERWRITE_PEEK_BURST_DEFINES_SVH

// Same-cycle implication, clocked on clk, quiet during reset.
`define FOPB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, quiet during reset.
`define FOPB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/fopb_pkg.sv */
// Shared types and constants of the overwrite/peek/burst ring buffer.
package fopb_pkg;

	localparam int FOPB_DEPTH     = 256;
	localparam int FOPB_MAX_BURST = 64;
	localparam int FOPB_CAP_RESET = 256;

	localparam int CMD_W   = 3;
	localparam int DATA_W  = 16;
	localparam int COUNT_W = 7;
	localparam int STAT_W  = 3;
	localparam int OCC_W   = 9;
	localparam int CFG_W   = 9;
	localparam int CFG_IDX_W = 1;

	// command codes
	localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_FLUSH = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SETW  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SETR  = 3'd4;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
	localparam logic [STAT_W-1:0] ST_FULL   = 3'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd2;
	localparam logic [STAT_W-1:0] ST_FEW    = 3'd3;
	localparam logic [STAT_W-1:0] ST_WPROT  = 3'd4;
	localparam logic [STAT_W-1:0] ST_RPROT  = 3'd5;
	localparam logic [STAT_W-1:0] ST_ZERO   = 3'd6;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OVERWRITE = 1'd1;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [DATA_W-1:0]  data_in;
		logic [COUNT_W-1:0] count;
		logic               keep;
		logic               bypass;
		logic               flag;
	} fopb_req_t;

	typedef struct packed {
		logic [DATA_W-1:0] data_out;
		logic [STAT_W-1:0] status;
		logic              last;
		logic [OCC_W-1:0]  occupancy;
		logic              is_empty;
		logic              is_full;
	} fopb_rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;   // transaction taken this cycle
		logic start;    // accepted pop that will burst
		logic emit;     // burst word goes to output register
		logic load;     // output register loads
	} fopb_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic pop_go;       // current pop request passes all checks
		logic burst_last;   // one word left in burst
	} fopb_sts_t;

endpackage

/* src/fopb_chan_if.sv */
// Valid/ready channel carrying one payload per transaction.
interface fopb_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

/* src/fopb_ram.sv */
// Generic single-write, single-read RAM with registered read.
module fopb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

/* src/fopb_ctrl.sv */
// Controller: handshake, burst sequencing and output-register valid.
`include "fifo_overwrite_peek_burst_defines.svh"
module fopb_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  logic [fopb_pkg::CMD_W-1:0]     req_cmd,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	input  fopb_pkg::fopb_sts_t            sts,
	output fopb_pkg::fopb_ctl_t            ctl
);
	import fopb_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_BURST
	} state_t;

	state_t state_q;
	logic   out_v_q;
	logic   ofree;
	logic   acc;
	logic   known;

	assign ofree     = !out_v_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE) && ofree;
	assign acc       = req_valid && req_ready;
	assign known     = (req_cmd <= CMD_SETR);

	always_comb begin
		ctl.accept = acc;
		ctl.start  = acc && (req_cmd == CMD_POP) && sts.pop_go;
		ctl.emit   = (state_q == S_BURST) && ofree;
		ctl.load   = (acc && !ctl.start && known) || ctl.emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_v_q <= 1'b0;
		end else begin
			out_v_q <= ctl.load || (out_v_q && !rsp_ready);
			unique case (state_q)
				S_IDLE: begin
					if (ctl.start) begin
						state_q <= S_BURST;
					end
				end
				S_BURST: begin
					if (ctl.emit && sts.burst_last) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid = out_v_q;

	`FOPB_ASSERT_NEXT(a_burst_enter, ctl.start, state_q == S_BURST, "burst not entered")
	`FOPB_ASSERT_NEXT(a_burst_exit, ctl.emit && sts.burst_last, state_q == S_IDLE,
		"burst did not end after last word")
endmodule

/* src/fopb_dp.sv */
// Datapath: ring pointers, occupancy, protection flags, config and result register.
`include "fifo_overwrite_peek_burst_defines.svh"
module fopb_dp #(
	parameter int DEPTH     = fopb_pkg::FOPB_DEPTH,
	parameter int MAX_BURST = fopb_pkg::FOPB_MAX_BURST
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fopb_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [fopb_pkg::CFG_W-1:0]       cfg_data,
	input  fopb_pkg::fopb_req_t              req,
	input  fopb_pkg::fopb_ctl_t              ctl,
	output fopb_pkg::fopb_sts_t              sts,
	output fopb_pkg::fopb_rsp_t              rsp_data
);
	import fopb_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int BW = $clog2(MAX_BURST + 1);
	localparam int CAP_RST = (FOPB_CAP_RESET > DEPTH) ? DEPTH : FOPB_CAP_RESET;

	logic [PW-1:0] rp_q, rp_d, wp_q, wp_d, cur_q, cur_d;
	logic [CW-1:0] count_q, count_d, cap_q, cap_d, cap_sat;
	logic [BW-1:0] rem_q, rem_d;
	logic          wb_q, wb_d, rb_q, rb_d, keep_q, keep_d, ovw_q, ovw_d;
	logic          ram_we, ram_re;
	logic [PW-1:0] ram_raddr;
	logic [DATA_W-1:0] ram_rdata;
	logic [DATA_W-1:0] dout;
	logic [STAT_W-1:0] status;
	logic              lst;
	fopb_rsp_t         rsp_q;

	function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [CW-1:0] cap);
		logic [CW:0] n;
		n = {{(CW + 1 - PW){1'b0}}, p} + 1'b1;
		return (n >= {1'b0, cap}) ? '0 : n[PW-1:0];
	endfunction

	// saturate capacity to 2..DEPTH
	assign cap_sat = (cfg_data < CFG_W'(2)) ? CW'(2) :
		((32'(cfg_data) > DEPTH) ? CW'(DEPTH) : CW'(cfg_data));

	assign sts.pop_go = (req.count != '0) && !rb_q && (count_q != '0) &&
		(32'(req.count) <= MAX_BURST) && (32'(count_q) >= 32'(req.count));
	assign sts.burst_last = (rem_q == BW'(1));

	always_comb begin
		rp_d = rp_q; wp_d = wp_q; cur_d = cur_q;
		count_d = count_q; cap_d = cap_q; ovw_d = ovw_q;
		wb_d = wb_q; rb_d = rb_q; rem_d = rem_q; keep_d = keep_q;
		ram_we = 1'b0; ram_re = 1'b0; ram_raddr = cur_q;
		dout = '0; status = ST_OK; lst = 1'b1;

		if (cfg_we) begin
			unique case (cfg_idx)
				CFG_CAPACITY: begin
					cap_d = cap_sat;
					rp_d = '0; wp_d = '0; count_d = '0;
				end
				CFG_OVERWRITE: ovw_d = cfg_data[0];
				default: ;
			endcase
		end

		if (ctl.start) begin
			// first read of the burst; data arrives next cycle
			ram_re = 1'b1;
			ram_raddr = rp_q;
			cur_d = adv(rp_q, cap_q);
			rem_d = BW'(req.count);
			keep_d = req.keep;
		end else if (ctl.accept) begin
			unique case (req.cmd)
				CMD_PUSH: begin
					if (wb_q) begin
						status = ST_WPROT;
					end else if (count_q < cap_q) begin
						ram_we = 1'b1;
						wp_d = adv(wp_q, cap_q);
						count_d = count_q + 1'b1;
					end else if (ovw_q) begin
						// full ring: oldest word dropped
						ram_we = 1'b1;
						wp_d = adv(wp_q, cap_q);
						rp_d = adv(rp_q, cap_q);
					end else begin
						status = ST_FULL;
					end
				end
				CMD_POP: begin
					if (req.count == '0) status = ST_ZERO;
					else if (rb_q) status = ST_RPROT;
					else if (count_q == '0) status = ST_EMPTY;
					else status = ST_FEW;
				end
				CMD_FLUSH: begin
					if (!req.bypass && rb_q) begin
						status = ST_RPROT;
					end else if (!req.bypass && wb_q) begin
						status = ST_WPROT;
					end else begin
						rp_d = '0; wp_d = '0; count_d = '0;
						wb_d = 1'b0; rb_d = 1'b0;
					end
				end
				CMD_SETW: wb_d = req.flag;
				CMD_SETR: rb_d = req.flag;
				default: ;
			endcase
		end

		if (ctl.emit) begin
			dout = ram_rdata;
			lst = (rem_q == BW'(1));
			rem_d = rem_q - 1'b1;
			if (!keep_q) begin
				rp_d = adv(rp_q, cap_q);
				count_d = count_q - 1'b1;
			end
			if (rem_q != BW'(1)) begin
				ram_re = 1'b1;
				ram_raddr = cur_q;
				cur_d = adv(cur_q, cap_q);
			end
		end
	end

	fopb_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (req.data_in),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q <= '0;
			wp_q <= '0;
			count_q <= '0;
			cap_q <= CW'(CAP_RST);
			ovw_q <= 1'b0;
			wb_q <= 1'b0;
			rb_q <= 1'b0;
			rem_q <= '0;
		end else begin
			rp_q <= rp_d;
			wp_q <= wp_d;
			count_q <= count_d;
			cap_q <= cap_d;
			ovw_q <= ovw_d;
			wb_q <= wb_d;
			rb_q <= rb_d;
			rem_q <= rem_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		keep_q <= keep_d;
		if (ctl.load) begin
			rsp_q.data_out  <= dout;
			rsp_q.status    <= status;
			rsp_q.last      <= lst;
			rsp_q.occupancy <= OCC_W'(count_d);
			rsp_q.is_empty  <= (count_d == '0);
			rsp_q.is_full   <= (count_d == cap_d);
		end
	end

	assign rsp_data = rsp_q;

	`FOPB_ASSERT_NOW(a_count_cap, 1'b1, count_q <= cap_q, "occupancy above capacity")
	`FOPB_ASSERT_NOW(a_ptr_range, 1'b1, ({1'b0, rp_q} < {1'b0, cap_q}) &&
		({1'b0, wp_q} < {1'b0, cap_q}), "pointer outside capacity")
	`FOPB_ASSERT_NOW(a_empty_ptrs, count_q == '0, rp_q == wp_q, "empty ring with split pointers")
endmodule

/* src/fifo_overwrite_peek_burst.sv */
// Ring buffer FIFO of 16-bit words with programmable capacity, overwrite, peek and burst pop.
//
// Each request transaction on req yields results on rsp: one result for push, flush,
// set-write-block, set-read-block and for any failing pop; a good pop burst of N words
// yields N results, the final one with last set (peek with keep leaves the ring as it
// was). Codes 5..7 in cmd are taken and produce nothing. Push, flush, set commands
// and failing pops are taken back to back, as long as rsp keeps up. A pop burst of
// N words first reads them from the ring RAM, whose read is registered, and then
// yields one word per cycle while rsp takes them; req.ready is low for the length
// of the burst. The result register decouples the two sides, so a new request is
// taken in the same cycle a waiting result leaves. Configuration writes
// (capacity at index 0, saturated to 2..DEPTH and emptying the ring; overwrite mode
// at index 1) take effect at the next edge and are meant for idle periods only.
// There is no clearing pass after reset; ring entries are only read once written.
module fifo_overwrite_peek_burst #(
	parameter int DEPTH     = fopb_pkg::FOPB_DEPTH,
	parameter int MAX_BURST = fopb_pkg::FOPB_MAX_BURST
) (
	input  logic                           clk,
	input  logic                           arst_n,
	fopb_chan_if.sink                      req,
	fopb_chan_if.source                    rsp,
	input  logic                           cfg_we,
	input  logic [fopb_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [fopb_pkg::CFG_W-1:0]     cfg_data
);
	import fopb_pkg::*;

	fopb_ctl_t ctl;   // controller commands
	fopb_sts_t sts;   // datapath status
	fopb_req_t req_pl;
	fopb_rsp_t rsp_pl;

	assign req_pl = req.payload;

	// Controller: owns the handshake and the burst sequence.
	fopb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_cmd   (req_pl.cmd),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	// Datapath: ring RAM, pointers, flags, config registers, result register.
	fopb_dp #(
		.DEPTH     (DEPTH),
		.MAX_BURST (MAX_BURST)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.req      (req_pl),
		.ctl      (ctl),
		.sts      (sts),
		.rsp_data (rsp_pl)
	);

	assign rsp.payload = rsp_pl;
endmodule

/* tb/tb_fifo_overwrite_peek_burst.sv */
// Self-checking testbench for the overwrite/peek/burst ring buffer FIFO.
`timescale 1ns / 100ps

module tb_fifo_overwrite_peek_burst;
	import fopb_pkg::*;

	// cmd codes 5..7 are taken by the block and produce nothing
	localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;

	localparam int WATCHDOG_LIMIT = 3000; // quiet cycles before giving up
	localparam int HOLD_CYCLES    = 400;  // receiver hold-off in the fill test
	localparam int SETTLE_CYCLES  = 6;    // idle cycles before a register write
	localparam int PHASE_ITEMS    = 14;
	localparam int FILL_WORDS     = 80;   // > MAX_BURST so a too-long burst can be tried
	localparam int PRINT_LIMIT    = 40;
	localparam int N_PHASES       = 9;

	// capacity/overwrite settings per random phase: minimum, maximum and
	// out-of-range values that saturate to the legal range
	localparam logic [CFG_W-1:0] CAP_PLAN [N_PHASES] =
		'{9'd2, 9'd2, 9'd3, 9'd0, 9'd17, 9'd511, 9'd1, 9'd300, 9'd256};
	localparam logic OW_PLAN [N_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};

	// Directed table row. With pin set the single result is typed in here
	// (data zero, last set); otherwise the predictor supplies it.
	typedef struct packed {
		fopb_req_t         req;
		logic              pin;
		logic [STAT_W-1:0] st;
		logic [OCC_W-1:0]  occ;
	} dir_row_t;

	// fields: cmd, data_in, count, keep, bypass, flag
	localparam dir_row_t DIRECTED [25] = '{
		'{'{CMD_POP,        16'h0000, 7'd0,   1'b0, 1'b0, 1'b0}, 1'b1, ST_ZERO,  9'd0},
		'{'{CMD_POP,        16'h0000, 7'd1,   1'b0, 1'b0, 1'b0}, 1'b1, ST_EMPTY, 9'd0},
		'{'{CMD_POP,        16'hFFFF, 7'd127, 1'b1, 1'b1, 1'b1}, 1'b1, ST_EMPTY, 9'd0},
		'{'{CMD_FLUSH,      16'h0000, 7'd0,   1'b0, 1'b0, 1'b0}, 1'b1, ST_OK,    9'd0},
		'{'{CMD_RSVD_FIRST, 16'h0000, 7'd0,   1'b0, 1'b0, 1'b0}, 1'b0, ST_OK,    9'd0},
		'{'{CMD_PUSH,       16'hFFFF, 7'd0,   1'b0, 1'b0, 1'b0}, 1'b1, ST_OK,    9'd1},
		'{'{CMD_PUSH,       16'h0000, 7'd127, 1'b1, 1'b1, 1'b1}, 1'b1, ST_OK,    9'd2},
		'{'{CMD_PUSH,       16'hA5A5, 7'd0,   1'b0, 1'b0, 1'b0}, 1'b1, ST_OK,    9'd3},
		'{'{CMD_RSVD_LAST,  16'hFFFF, 7'd127, 1'b1, 1'b1, 1'b1}, 1'b0, ST_OK,    9'd0},
		'{'{CMD_POP,        16'h0000, 7'd4,   1'b0, 1'b0, 1'b0}, 1'b1, ST_FEW,   9'd3},
		'{'{CMD_POP,        16'h0000, 7'd3,   1'b1, 1'b0, 1'b0}, 1'b0, ST_OK,    9'd0},
		'{'{CMD_POP,        16'h0000, 7'd2,   1'b0, 1'b0, 1'b0}, 1'b0, ST_OK,    9'd0},
		'{'{CMD_SETR,       16'h0000, 7'd0,   1'b0, 1'b0, 1'b1}, 1'b1, ST_OK,    9'd1},
		'{'{CMD_POP,        16'h0000, 7'd1,   1'b0, 1'b0, 1'b0}, 1'b1, ST_RPROT, 9'd1},
		'{'{CMD_POP,        16'h0000, 7'd0,   1'b0, 1'b0, 1'b0}, 1'b1, ST_ZERO,  9'd1},
		'{'{CMD_SETW,       16'h0000, 7'd0,   1'b0, 1'b0, 1'b1}, 1'b1, ST_OK,    9'd1},
		'{'{CMD_PUSH,       16'h5A5A, 7'd0,   1'b0, 1'b0, 1'b0}, 1'b1, ST_WPROT, 9'd1},
		'{'{CMD_FLUSH,      16'h0000, 7'd0,   1'b0, 1'b0, 1'b0}, 1'b1, ST_RPROT, 9'd1},
		'{'{CMD_SETR,       16'h0000, 7'd0,   1'b0, 1'b0, 1'b0}, 1'b1, ST_OK,    9'd1},
		'{'{CMD_FLUSH,      16'h0000, 7'd0,   1'b0, 1'b0, 1'b0}, 1'b1, ST_WPROT, 9'd1},
		'{'{CMD_FLUSH,      16'h0000, 7'd0,   1'b0, 1'b1, 1'b0}, 1'b1, ST_OK,    9'd0},
		'{'{CMD_PUSH,       16'h1234, 7'd0,   1'b0, 1'b0, 1'b0}, 1'b1, ST_OK,    9'd1},
		'{'{CMD_POP,        16'h0000, 7'd1,   1'b0, 1'b0, 1'b0}, 1'b0, ST_OK,    9'd0},
		'{'{CMD_SETW,       16'hFFFF, 7'd127, 1'b1, 1'b1, 1'b0}, 1'b1, ST_OK,    9'd0},
		'{'{CMD_PUSH,       16'h8001, 7'd64,  1'b1, 1'b1, 1'b1}, 1'b1, ST_OK,    9'd1}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_data;

	fopb_chan_if #(.T(fopb_req_t)) req_if ();
	fopb_chan_if #(.T(fopb_rsp_t)) rsp_if ();

	fifo_overwrite_peek_burst uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_if),
		.rsp      (rsp_if),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// ---------------------------------------------------------------
	// Predictor state: its own copy of the ring, pointers and config
	// ---------------------------------------------------------------
	logic [DATA_W-1:0] ring_mem [FOPB_DEPTH];
	int   rd_idx = 0;
	int   wr_idx = 0;
	int   fill   = 0;
	logic wr_lock = 1'b0;
	logic rd_lock = 1'b0;
	int   cap_q  = FOPB_CAP_RESET;
	logic ow_q   = 1'b0;

	fopb_rsp_t owed_results [$];   // results still due from the block

	// typed-in expectation travelling with the request currently offered
	logic              pin_en;
	logic [STAT_W-1:0] pin_st;
	logic [OCC_W-1:0]  pin_occ;

	logic rx_hold = 1'b0;          // asks the receiver for one long hold-off
	int   tx_calm = 0;             // remaining items sent back to back

	int errs = 0;
	int n_items = 0;
	int n_results = 0;
	int n_words = 0;
	int n_overwrites = 0;
	int n_holds = 0;
	int idle_cycles = 0;

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		errs++;
		if (errs <= PRINT_LIMIT)
			$display("%0t: mismatch on %s after %0d results: got 0x%0h, expected 0x%0h",
				$time, what, n_results, got, want);
	endtask

	function automatic int ring_next(input int p);
		return (p + 1 >= cap_q) ? 0 : p + 1;
	endfunction

	function automatic fopb_rsp_t mk_rsp(input logic [DATA_W-1:0] d,
			input logic [STAT_W-1:0] st, input logic lst, input int occ);
		fopb_rsp_t x;
		x.data_out  = d;
		x.status    = st;
		x.last      = lst;
		x.occupancy = occ[OCC_W-1:0];
		x.is_empty  = (occ == 0);
		x.is_full   = (occ == cap_q);
		return x;
	endfunction

	// Capacity writes saturate to 2..DEPTH and empty the ring, but leave
	// the protection flags alone.
	task automatic cfg_apply(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		int c;
		if (idx == CFG_CAPACITY) begin
			c = int'(val);
			if (c < 2)
				c = 2;
			if (c > FOPB_DEPTH)
				c = FOPB_DEPTH;
			cap_q  = c;
			rd_idx = 0;
			wr_idx = 0;
			fill   = 0;
		end else begin
			ow_q = val[0];
		end
	endtask

	// Works out every result one accepted request causes and queues them.
	task automatic ring_apply_cmd(input fopb_req_t r);
		int cnt;
		int walk;
		int left;
		int i;
		cnt = int'(r.count);
		case (r.cmd)
			CMD_PUSH: begin
				if (wr_lock) begin
					owed_results.push_back(mk_rsp('0, ST_WPROT, 1'b1, fill));
				end else if (fill < cap_q || ow_q) begin
					ring_mem[wr_idx] = r.data_in;
					wr_idx = ring_next(wr_idx);
					if (fill < cap_q) begin
						fill++;
					end else begin
						// full ring in overwrite mode: oldest word is dropped
						rd_idx = ring_next(rd_idx);
						n_overwrites++;
					end
					owed_results.push_back(mk_rsp('0, ST_OK, 1'b1, fill));
				end else begin
					owed_results.push_back(mk_rsp('0, ST_FULL, 1'b1, fill));
				end
			end
			CMD_POP: begin
				// check order: zero count, read protection, empty, too few/too long
				if (cnt == 0) begin
					owed_results.push_back(mk_rsp('0, ST_ZERO, 1'b1, fill));
				end else if (rd_lock) begin
					owed_results.push_back(mk_rsp('0, ST_RPROT, 1'b1, fill));
				end else if (fill == 0) begin
					owed_results.push_back(mk_rsp('0, ST_EMPTY, 1'b1, fill));
				end else if (cnt > FOPB_MAX_BURST || cnt > fill) begin
					owed_results.push_back(mk_rsp('0, ST_FEW, 1'b1, fill));
				end else begin
					walk = rd_idx;
					left = fill;
					for (i = 0; i < cnt; i++) begin
						if (!r.keep)
							left--;
						owed_results.push_back(mk_rsp(ring_mem[walk], ST_OK,
							i == cnt - 1, left));
						walk = ring_next(walk);
					end
					// a peek leaves the pointers and occupancy untouched
					if (!r.keep) begin
						rd_idx = walk;
						fill   = left;
					end
					n_words += cnt;
				end
			end
			CMD_FLUSH: begin
				if (!r.bypass && rd_lock) begin
					owed_results.push_back(mk_rsp('0, ST_RPROT, 1'b1, fill));
				end else if (!r.bypass && wr_lock) begin
					owed_results.push_back(mk_rsp('0, ST_WPROT, 1'b1, fill));
				end else begin
					rd_idx  = 0;
					wr_idx  = 0;
					fill    = 0;
					wr_lock = 1'b0;
					rd_lock = 1'b0;
					owed_results.push_back(mk_rsp('0, ST_OK, 1'b1, fill));
				end
			end
			CMD_SETW: begin
				wr_lock = r.flag;
				owed_results.push_back(mk_rsp('0, ST_OK, 1'b1, fill));
			end
			CMD_SETR: begin
				rd_lock = r.flag;
				owed_results.push_back(mk_rsp('0, ST_OK, 1'b1, fill));
			end
			default: ;   // reserved codes: accepted, nothing comes back
		endcase
	endtask

	// ---------------------------------------------------------------
	// Monitor: sampled at the rising edge only. Results are checked
	// before the request of the same edge is predicted, so a result
	// can never be matched against an expectation it did not cause.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		fopb_rsp_t got;
		fopb_rsp_t want;
		int base;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				got = rsp_if.payload;
				n_results++;
				if (owed_results.size() == 0) begin
					report_mismatch("result with nothing awaited, status", got.status, 0);
				end else begin
					want = owed_results.pop_front();
					if (got.data_out !== want.data_out)
						report_mismatch("data_out", got.data_out, want.data_out);
					if (got.status !== want.status)
						report_mismatch("status", got.status, want.status);
					if (got.last !== want.last)
						report_mismatch("last", got.last, want.last);
					if (got.occupancy !== want.occupancy)
						report_mismatch("occupancy", got.occupancy, want.occupancy);
					if (got.is_empty !== want.is_empty)
						report_mismatch("is_empty", got.is_empty, want.is_empty);
					if (got.is_full !== want.is_full)
						report_mismatch("is_full", got.is_full, want.is_full);
				end
			end
			if (cfg_we)
				cfg_apply(cfg_idx, cfg_data);
			if (req_if.valid && req_if.ready) begin
				n_items++;
				base = owed_results.size();
				ring_apply_cmd(req_if.payload);
				// directed rows with a typed-in answer override the predictor
				if (pin_en && owed_results.size() == base + 1)
					owed_results[base] = mk_rsp('0, pin_st, 1'b1, int'(pin_occ));
			end
		end
	end

	// Watchdog: ends the run when no transaction moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog, no transaction for %0d cycles, %0d results outstanding",
					$time, idle_cycles, owed_results.size());
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Receiver: random back-pressure, driven at the falling edge.
	// Mostly short stalls, a few long ones, calm stretches with ready
	// held high, and one long hold-off on request.
	// ---------------------------------------------------------------
	initial begin
		int stall;
		int calm;
		int r;
		stall = 0;
		calm = 0;
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold) begin
				rx_hold = 1'b0;
				stall = HOLD_CYCLES;
				n_holds++;
			end
			if (stall > 0) begin
				stall--;
				rsp_if.ready <= 1'b0;
			end else if (calm > 0) begin
				calm--;
				rsp_if.ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					rsp_if.ready <= 1'b1;
				end else if (r < 65) begin
					calm = $urandom_range(15, 60);
					rsp_if.ready <= 1'b1;
				end else if (r < 94) begin
					stall = $urandom_range(0, 2);
					rsp_if.ready <= 1'b0;
				end else begin
					stall = $urandom_range(8, 40);
					rsp_if.ready <= 1'b0;
				end
			end
		end
	end

	// sender gap before the next request: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		if (tx_calm > 0) begin
			tx_calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 8) begin
			tx_calm = $urandom_range(10, 40);
			return 0;
		end
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Random request: pushes and small pops dominate so the ring actually
	// fills and drains; zero, oversized counts and reserved codes are noise.
	function automatic fopb_req_t rand_item();
		fopb_req_t r;
		int sel;
		int c;
		r.data_in = 16'($urandom);
		r.keep    = ($urandom_range(0, 9) < 3);
		r.bypass  = 1'($urandom);
		r.flag    = 1'($urandom);
		c = $urandom_range(0, 99);
		if (c < 8)
			r.count = '0;
		else if (c < 18)
			r.count = 7'($urandom_range(9, 127));
		else
			r.count = 7'($urandom_range(1, 6));
		sel = $urandom_range(0, 99);
		if (sel < 46) begin
			r.cmd = CMD_PUSH;
		end else if (sel < 78) begin
			r.cmd = CMD_POP;
		end else if (sel < 84) begin
			r.cmd = CMD_FLUSH;
		end else if (sel < 90) begin
			r.cmd  = CMD_SETW;
			r.flag = ($urandom_range(0, 9) < 3);   // keep protection mostly off
		end else if (sel < 96) begin
			r.cmd  = CMD_SETR;
			r.flag = ($urandom_range(0, 9) < 3);
		end else begin
			r.cmd = 3'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
		end
		return r;
	endfunction

	// Offers one request after an optional gap and holds it until taken.
	// Everything changes at the falling edge; acceptance is seen at the rising one.
	task automatic send_item(input fopb_req_t r, input int gap, input logic pin,
			input logic [STAT_W-1:0] st, input logic [OCC_W-1:0] occ);
		repeat (gap) begin
			@(negedge clk);
			req_if.valid <= 1'b0;
		end
		@(negedge clk);
		req_if.valid   <= 1'b1;
		req_if.payload <= r;
		pin_en  <= pin;
		pin_st  <= st;
		pin_occ <= occ;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
	endtask

	// Stops sending and waits for every due result, then idles for SETTLE_CYCLES
	// in case a reserved code is still being swallowed.
	task automatic wait_drained();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (owed_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	initial begin
		int ph;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_idx        = CFG_CAPACITY;
		cfg_data       = '0;
		req_if.valid   = 1'b0;
		req_if.payload = '0;
		pin_en         = 1'b0;
		pin_st         = ST_OK;
		pin_occ        = '0;
		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset state, every command, protection and error paths
		foreach (DIRECTED[i])
			send_item(DIRECTED[i].req, pick_gap(), DIRECTED[i].pin, DIRECTED[i].st,
				DIRECTED[i].occ);

		// random phases, each under its own capacity/overwrite setting
		for (ph = 0; ph < N_PHASES; ph++) begin
			wait_drained();
			write_reg(CFG_CAPACITY, CAP_PLAN[ph]);
			write_reg(CFG_OVERWRITE, 9'(OW_PLAN[ph]));
			repeat (PHASE_ITEMS)
				send_item(rand_item(), pick_gap(), 1'b0, ST_OK, '0);
		end

		// fill test: receiver holds off while pushes keep coming, so the
		// block backs up and stalls its input; then long bursts drain it
		wait_drained();
		write_reg(CFG_CAPACITY, 9'd256);
		write_reg(CFG_OVERWRITE, 9'd0);
		send_item(fopb_req_t'{CMD_FLUSH, 16'h0000, 7'd0, 1'b0, 1'b1, 1'b0}, 0, 1'b0, ST_OK, '0);
		rx_hold = 1'b1;
		repeat (FILL_WORDS)
			send_item(fopb_req_t'{CMD_PUSH, 16'($urandom), 7'd0, 1'b0, 1'b0, 1'b0}, 0,
				1'b0, ST_OK, '0);
		// longer than MAX_BURST, then a full-length peek, a pop and the rest
		send_item(fopb_req_t'{CMD_POP, 16'h0000, 7'd65, 1'b0, 1'b0, 1'b0}, 0, 1'b0, ST_OK, '0);
		send_item(fopb_req_t'{CMD_POP, 16'h0000, 7'd64, 1'b1, 1'b0, 1'b0}, 0, 1'b0, ST_OK, '0);
		send_item(fopb_req_t'{CMD_POP, 16'h0000, 7'd64, 1'b0, 1'b0, 1'b0}, 0, 1'b0, ST_OK, '0);
		send_item(fopb_req_t'{CMD_POP, 16'h0000, 7'd16, 1'b0, 1'b0, 1'b0}, 0, 1'b0, ST_OK, '0);

		wait_drained();
		if (owed_results.size() != 0)
			report_mismatch("results never delivered", owed_results.size(), 0);

		$display("Run covered %0d request and %0d result transactions: %0d burst words,",
			n_items, n_results, n_words);
		$display("%0d overwrites, capacities 2..256 with saturated writes, %0d long hold(s).",
			n_overwrites, n_holds);
		if (errs == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
